>>> design/mpte_pkg.sv
// shared types, codes and constants of the meter poll transaction engine
package mpte_pkg;

	localparam int          FRAME_BYTES   = 7;
	localparam int          CFG_INDEX_W   = 1;
	localparam int          CFG_DATA_W    = 20;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [19:0] ADDR_MODULUS  = 20'd1000000;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_METER_ADDRESS,
		REG_TIMEOUT_TICKS
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_BEGIN,
		ACT_SEND,
		ACT_BYTE,
		ACT_TICK
	} action_t;

	typedef enum logic [1:0] {
		KIND_TX_BYTE,
		KIND_DIR,
		KIND_PAYLOAD,
		KIND_STATUS
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_TIMEOUT,
		ST_BAD_CRC,
		ST_REFUSED
	} status_t;

	typedef enum logic [2:0] {
		SEL_DIR_TX,
		SEL_TX_BYTE,
		SEL_DIR_RX,
		SEL_PAYLOAD,
		SEL_STATUS
	} res_sel_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] cmd_code;
		logic [4:0] resp_data_len;
		logic [7:0] rx_byte;
	} mpte_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       dir_send;
		logic [1:0] status;
		logic       last;
	} mpte_result_t;

	typedef struct packed {
		logic     capture;
		logic     tx_start;
		logic     tick;
		logic     rx_write;
		logic     pay_init;
		logic     pay_read;
		logic     emit;
		res_sel_t sel;
		status_t  status;
		logic     last;
	} mpte_cmd_t;

	typedef struct packed {
		action_t action;
		logic    out_free;
		logic    timeout_hit;
		logic    rx_done;
		logic    crc_ok;
		logic    tx_final;
		logic    pay_more;
	} mpte_stat_t;

	// one byte of crc-16, reflected polynomial, lsb first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		int          k;
		c = crc ^ {8'h00, b};
		for (k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> design/mpte_ctrl.sv
// controller state machine of the meter poll transaction engine
module mpte_ctrl
	import mpte_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	output mpte_cmd_t  cmd,
	input  mpte_stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RX_CHK,
		S_PAY_CHK,
		S_PAY_EMIT,
		S_STATUS,
		S_DIR_TX,
		S_TX,
		S_DIR_RX
	} state_t;

	state_t  state_q;
	logic    waiting_q;
	logic    latch_q;
	status_t st_code_q;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.sel    = SEL_STATUS;
		cmd.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.capture = item_valid;
			end
			S_DECODE: begin
				case (stat.action)
					ACT_SEND: cmd.tx_start = !(waiting_q || latch_q);
					ACT_TICK: cmd.tick = waiting_q;
					ACT_BYTE: cmd.rx_write = waiting_q;
					default: ;
				endcase
			end
			S_RX_CHK: begin
				cmd.pay_init = stat.rx_done && stat.crc_ok;
			end
			S_PAY_CHK: begin
				cmd.pay_read = stat.pay_more;
			end
			S_PAY_EMIT: begin
				cmd.emit = stat.out_free;
				cmd.sel  = SEL_PAYLOAD;
			end
			S_STATUS: begin
				cmd.emit   = stat.out_free;
				cmd.sel    = SEL_STATUS;
				cmd.status = st_code_q;
				cmd.last   = 1'b1;
			end
			S_DIR_TX: begin
				cmd.emit = stat.out_free;
				cmd.sel  = SEL_DIR_TX;
			end
			S_TX: begin
				cmd.emit = stat.out_free;
				cmd.sel  = SEL_TX_BYTE;
			end
			S_DIR_RX: begin
				cmd.emit = stat.out_free;
				cmd.sel  = SEL_DIR_RX;
				cmd.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			waiting_q <= 1'b0;
			latch_q   <= 1'b0;
			st_code_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					case (stat.action)
						ACT_BEGIN: begin
							if (!waiting_q) latch_q <= 1'b0;
							state_q <= S_IDLE;
						end
						ACT_SEND: begin
							if (waiting_q || latch_q) begin
								st_code_q <= ST_REFUSED;
								state_q   <= S_STATUS;
							end else begin
								state_q <= S_DIR_TX;
							end
						end
						ACT_TICK: begin
							if (waiting_q && stat.timeout_hit) begin
								waiting_q <= 1'b0;
								latch_q   <= 1'b1;
								st_code_q <= ST_TIMEOUT;
								state_q   <= S_STATUS;
							end else begin
								state_q <= S_IDLE;
							end
						end
						ACT_BYTE: begin
							state_q <= waiting_q ? S_RX_CHK : S_IDLE;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_RX_CHK: begin
					if (stat.rx_done) begin
						waiting_q <= 1'b0;
						if (stat.crc_ok) begin
							state_q <= S_PAY_CHK;
						end else begin
							latch_q   <= 1'b1;
							st_code_q <= ST_BAD_CRC;
							state_q   <= S_STATUS;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PAY_CHK: begin
					if (stat.pay_more) begin
						state_q <= S_PAY_EMIT;
					end else begin
						st_code_q <= ST_OK;
						state_q   <= S_STATUS;
					end
				end
				S_PAY_EMIT: begin
					if (stat.out_free) state_q <= S_PAY_CHK;
				end
				S_STATUS: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				S_DIR_TX: begin
					if (stat.out_free) state_q <= S_TX;
				end
				S_TX: begin
					if (stat.out_free && stat.tx_final) state_q <= S_DIR_RX;
				end
				S_DIR_RX: begin
					if (stat.out_free) begin
						waiting_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> design/mpte_datapath.sv
// datapath: config registers, crc, response store, counters and result register
module mpte_datapath
	import mpte_pkg::*;
#(
	parameter int MAX_DATA = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mpte_item_t             item,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  mpte_cmd_t              cmd,
	output mpte_stat_t             stat,
	output logic                   result_valid,
	input  logic                   result_stall,
	output mpte_result_t           result
);

	localparam int STORE_DEPTH = FRAME_BYTES + MAX_DATA;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W       = $clog2(STORE_DEPTH);

	mpte_item_t   item_q;
	logic [19:0]  meter_q;
	logic [15:0]  timeout_q;
	logic [19:0]  addr_q;
	logic [15:0]  crc_q;
	logic [2:0]   tx_idx_q;
	logic [CNT_W-1:0] needed_q;
	logic [CNT_W-1:0] rx_count_q;
	logic [IDX_W-1:0] pay_idx_q;
	logic [15:0]  elapsed_q;
	logic [7:0]   got_lo_q;
	logic [7:0]   got_hi_q;
	logic [7:0]   rd_q;
	logic [7:0]   mem_q [STORE_DEPTH];
	logic         result_valid_q;
	mpte_result_t result_q;

	logic [19:0]      addr_red;
	logic [15:0]      elapsed_inc;
	logic [CNT_W-1:0] dlen_sat;
	logic [CNT_W-1:0] needed_m2;
	logic [7:0]       tx_byte;
	mpte_result_t     res_next;

	// address is below twice the modulus, so one subtract reduces it
	assign addr_red    = (meter_q >= ADDR_MODULUS) ? meter_q - ADDR_MODULUS : meter_q;
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign needed_m2   = needed_q - CNT_W'(2);

	always_comb begin
		if (int'(item_q.resp_data_len) > MAX_DATA) begin
			dlen_sat = CNT_W'(MAX_DATA);
		end else begin
			dlen_sat = CNT_W'(item_q.resp_data_len);
		end
	end

	always_comb begin
		case (tx_idx_q)
			3'd0:    tx_byte = 8'h00;
			3'd1:    tx_byte = {4'h0, addr_q[19:16]};
			3'd2:    tx_byte = addr_q[15:8];
			3'd3:    tx_byte = addr_q[7:0];
			3'd4:    tx_byte = item_q.cmd_code;
			3'd5:    tx_byte = crc_q[7:0];
			3'd6:    tx_byte = crc_q[15:8];
			default: tx_byte = 8'h00;
		endcase
	end

	always_comb begin
		stat.action      = action_t'(item_q.action);
		stat.out_free    = !result_valid_q || !result_stall;
		stat.timeout_hit = (elapsed_inc > timeout_q);
		stat.rx_done     = (rx_count_q >= needed_q);
		stat.crc_ok      = (crc_q == {got_hi_q, got_lo_q});
		stat.tx_final    = (tx_idx_q == 3'd6);
		stat.pay_more    = (CNT_W'(pay_idx_q) < needed_m2);
	end

	always_comb begin
		res_next      = '0;
		res_next.last = cmd.last;
		case (cmd.sel)
			SEL_DIR_TX: begin
				res_next.kind     = KIND_DIR;
				res_next.dir_send = 1'b1;
			end
			SEL_TX_BYTE: begin
				res_next.kind      = KIND_TX_BYTE;
				res_next.data_byte = tx_byte;
				res_next.dir_send  = 1'b1;
			end
			SEL_DIR_RX: begin
				res_next.kind = KIND_DIR;
			end
			SEL_PAYLOAD: begin
				res_next.kind      = KIND_PAYLOAD;
				res_next.data_byte = rd_q;
			end
			SEL_STATUS: begin
				res_next.kind   = KIND_STATUS;
				res_next.status = cmd.status;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_q        <= '0;
			timeout_q      <= TIMEOUT_RESET;
			tx_idx_q       <= '0;
			needed_q       <= '0;
			rx_count_q     <= '0;
			pay_idx_q      <= '0;
			elapsed_q      <= '0;
			crc_q          <= CRC_INIT;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_METER_ADDRESS: meter_q <= cfg_data;
					REG_TIMEOUT_TICKS: timeout_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.tx_start) begin
				crc_q      <= CRC_INIT;
				tx_idx_q   <= '0;
				needed_q   <= dlen_sat + CNT_W'(FRAME_BYTES);
				rx_count_q <= '0;
				elapsed_q  <= '0;
			end
			if (cmd.tick) elapsed_q <= elapsed_inc;
			if (cmd.rx_write) begin
				// the two trailing bytes are the received crc
				if (rx_count_q < needed_m2) crc_q <= crc_feed(crc_q, item_q.rx_byte);
				rx_count_q <= rx_count_q + CNT_W'(1);
			end
			if (cmd.pay_init) pay_idx_q <= IDX_W'(5);
			if (cmd.emit) begin
				case (cmd.sel)
					SEL_TX_BYTE: begin
						if (tx_idx_q < 3'd5) crc_q <= crc_feed(crc_q, tx_byte);
						tx_idx_q <= tx_idx_q + 3'd1;
					end
					SEL_DIR_RX: crc_q <= CRC_INIT;
					SEL_PAYLOAD: pay_idx_q <= pay_idx_q + IDX_W'(1);
					default: ;
				endcase
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		if (cmd.tx_start) addr_q <= addr_red;
		if (cmd.rx_write) begin
			if (rx_count_q == needed_m2) got_lo_q <= item_q.rx_byte;
			if (rx_count_q == needed_q - CNT_W'(1)) got_hi_q <= item_q.rx_byte;
		end
		if (cmd.emit) result_q <= res_next;
	end

	// response store
	always_ff @(posedge clk) begin
		if (cmd.rx_write) mem_q[rx_count_q[IDX_W-1:0]] <= item_q.rx_byte;
		if (cmd.pay_read) rd_q <= mem_q[pay_idx_q];
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> design/meter_poll_transaction_engine.sv
// one item at a time, accepted only while idle; begin, tick and ignored items pass through decode
// and return to idle, a refused send or a timeout tick through decode and a status result
// send: the first result follows decode, the other eight follow one per free output cycle
// received byte: decode then a completion check; a bad final byte adds the status, a good one adds
// a store read and a result register load per payload byte, then the status
// arst_n clears control state, meter_address to 0 and timeout_ticks to 1000; no clearing pass
module meter_poll_transaction_engine
	import mpte_pkg::*;
#(
	parameter int MAX_DATA = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  mpte_item_t             item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output mpte_result_t           result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	mpte_cmd_t  cmd;
	mpte_stat_t stat;

	assign cfg_ready = 1'b1;

	mpte_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.stat       (stat)
	);

	mpte_datapath #(
		.MAX_DATA (MAX_DATA)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> design/mpte_checker.sv
// port-level assertions for the meter poll transaction engine and their bind
module mpte_checker
	import mpte_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         item_valid,
	input logic         item_stall,
	input logic         result_valid,
	input logic         result_stall,
	input mpte_result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("engine took a second transaction while busy");

	a_tx_byte_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_TX_BYTE |-> result.dir_send && !result.last)
		else $error("transmit byte with wrong direction or last");

	a_payload_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_PAYLOAD |->
		!result.dir_send && !result.last)
		else $error("payload byte marked last or transmit");

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_STATUS |-> result.status == ST_OK)
		else $error("status code outside a status result");

endmodule

bind meter_poll_transaction_engine mpte_checker u_mpte_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> sim/meter_poll_transaction_engine_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the meter poll transaction engine
module meter_poll_transaction_engine_tb;
	import mpte_pkg::*;

	localparam int PAYLOAD_MAX  = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 60;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	mpte_item_t             item         = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	mpte_result_t           result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	meter_poll_transaction_engine #(.MAX_DATA(PAYLOAD_MAX)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// engine state as the testbench sees it
	logic [19:0]  eng_address = '0;
	logic [15:0]  eng_timeout = TIMEOUT_RESET;
	logic         eng_waiting = 1'b0;
	logic         eng_latch   = 1'b0;
	int           eng_rx_count  = 0;
	int           eng_rx_needed = 0;
	logic [15:0]  eng_elapsed = '0;
	logic [7:0]   eng_rx_store [FRAME_BYTES + PAYLOAD_MAX];
	mpte_result_t awaited [$];

	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int status_tally [4];
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[%0t] run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("meter_poll_transaction_engine regression: fail");
			$finish;
		end
	end

	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		int          i;
		r = acc;
		for (i = 0; i < 8; i++) begin
			r = (r[0] ^ d[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic void add_result(input kind_t k, input logic [7:0] b, input logic dir,
			input status_t st, input logic fin);
		mpte_result_t r;
		r.kind      = k;
		r.data_byte = b;
		r.dir_send  = dir;
		r.status    = st;
		r.last      = fin;
		awaited.insert(awaited.size(), r);
	endfunction

	// advance the engine state by one transaction and queue what it must emit
	function automatic void step_poll_engine(input mpte_item_t it);
		logic [7:0]  frame [FRAME_BYTES];
		logic [19:0] addr;
		logic [15:0] crc;
		logic [15:0] got;
		int          len;
		int          i;
		case (it.action)
			ACT_BEGIN: begin
				if (!eng_waiting) eng_latch = 1'b0;
			end
			ACT_SEND: begin
				if (eng_waiting || eng_latch) begin
					add_result(KIND_STATUS, 8'h00, 1'b0, ST_REFUSED, 1'b1);
				end else begin
					len  = (it.resp_data_len > PAYLOAD_MAX) ? PAYLOAD_MAX : it.resp_data_len;
					addr = eng_address % ADDR_MODULUS;
					frame[0] = 8'h00;
					frame[1] = {4'h0, addr[19:16]};
					frame[2] = addr[15:8];
					frame[3] = addr[7:0];
					frame[4] = it.cmd_code;
					crc = CRC_INIT;
					for (i = 0; i < 5; i++) crc = crc16_byte(crc, frame[i]);
					frame[5] = crc[7:0];
					frame[6] = crc[15:8];
					add_result(KIND_DIR, 8'h00, 1'b1, ST_OK, 1'b0);
					for (i = 0; i < FRAME_BYTES; i++) add_result(KIND_TX_BYTE, frame[i], 1'b1, ST_OK, 1'b0);
					add_result(KIND_DIR, 8'h00, 1'b0, ST_OK, 1'b1);
					eng_waiting   = 1'b1;
					eng_rx_count  = 0;
					eng_rx_needed = FRAME_BYTES + len;
					eng_elapsed   = '0;
				end
			end
			ACT_TICK: begin
				if (eng_waiting) begin
					if (eng_elapsed != 16'hFFFF) eng_elapsed++;
					if (eng_elapsed > eng_timeout) begin
						eng_waiting = 1'b0;
						eng_latch   = 1'b1;
						add_result(KIND_STATUS, 8'h00, 1'b0, ST_TIMEOUT, 1'b1);
					end
				end
			end
			ACT_BYTE: begin
				if (eng_waiting) begin
					if (eng_rx_count < eng_rx_needed) begin
						eng_rx_store[eng_rx_count] = it.rx_byte;
						eng_rx_count++;
					end
					if (eng_rx_count >= eng_rx_needed) begin
						eng_waiting = 1'b0;
						crc = CRC_INIT;
						for (i = 0; i < eng_rx_needed - 2; i++) crc = crc16_byte(crc, eng_rx_store[i]);
						got = {eng_rx_store[eng_rx_needed - 1], eng_rx_store[eng_rx_needed - 2]};
						if (got != crc) begin
							eng_latch = 1'b1;
							add_result(KIND_STATUS, 8'h00, 1'b0, ST_BAD_CRC, 1'b1);
						end else begin
							for (i = 5; i < eng_rx_needed - 2; i++)
								add_result(KIND_PAYLOAD, eng_rx_store[i], 1'b0, ST_OK, 1'b0);
							add_result(KIND_STATUS, 8'h00, 1'b0, ST_OK, 1'b1);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("[%0t] mismatch %0d, %s: got %0h, want %0h", $time, mismatches, what, got, want);
	endtask

	// long hold-offs come from hold_request, counted here
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// compare each delivered result, then fold each accepted transaction into the state
	always @(posedge clk) begin
		mpte_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (awaited.size() == 0) begin
					report_mismatch("result with nothing pending", 32'(result), 0);
				end else begin
					want = awaited.pop_front();
					if (result.kind !== want.kind)
						report_mismatch("kind", 32'(result.kind), 32'(want.kind));
					if (result.data_byte !== want.data_byte)
						report_mismatch("data_byte", 32'(result.data_byte), 32'(want.data_byte));
					if (result.dir_send !== want.dir_send)
						report_mismatch("dir_send", 32'(result.dir_send), 32'(want.dir_send));
					if (result.status !== want.status)
						report_mismatch("status", 32'(result.status), 32'(want.status));
					if (result.last !== want.last)
						report_mismatch("last", 32'(result.last), 32'(want.last));
					if (want.kind == KIND_STATUS) status_tally[want.status]++;
				end
			end
			if (item_valid && !item_stall) step_poll_engine(item);
		end
	end

	task automatic send_item(input mpte_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	// unused fields carry random values
	function automatic mpte_item_t make_item(input action_t act);
		mpte_item_t it;
		it.action        = act;
		it.cmd_code      = 8'($urandom);
		it.resp_data_len = 5'($urandom);
		it.rx_byte       = 8'($urandom);
		return it;
	endfunction

	task automatic send_action(input action_t act);
		send_item(make_item(act));
	endtask

	task automatic send_byte(input logic [7:0] b);
		mpte_item_t it;
		it         = make_item(ACT_BYTE);
		it.rx_byte = b;
		send_item(it);
	endtask

	task automatic send_command(input logic [7:0] cmd, input logic [4:0] len);
		mpte_item_t it;
		it               = make_item(ACT_SEND);
		it.cmd_code      = cmd;
		it.resp_data_len = len;
		send_item(it);
	endtask

	// meter reply: five header bytes, payload, crc low byte first
	task automatic answer_frame(input int len, input int tick_pct, input bit corrupt);
		logic [7:0]  frame [$];
		logic [15:0] crc;
		int          i;
		int          flip;
		crc = CRC_INIT;
		for (i = 0; i < 5 + len; i++) begin
			frame.insert(frame.size(), 8'($urandom));
			crc = crc16_byte(crc, frame[i]);
		end
		frame.insert(frame.size(), crc[7:0]);
		frame.insert(frame.size(), crc[15:8]);
		if (corrupt) begin
			flip = $urandom_range(frame.size() - 1);
			frame[flip] ^= 8'(1 << $urandom_range(7));
		end
		foreach (frame[k]) begin
			if ($urandom_range(99) < tick_pct) send_action(ACT_TICK);
			send_byte(frame[k]);
		end
	endtask

	task automatic random_poll();
		logic [4:0] req_len;
		int         len;
		int         pick;
		int         i;
		pick    = $urandom_range(99);
		req_len = ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(4));
		len     = (req_len > PAYLOAD_MAX) ? PAYLOAD_MAX : req_len;
		if ($urandom_range(9) != 0) send_action(ACT_BEGIN);
		send_command(8'($urandom), req_len);
		if (pick < 60) begin
			answer_frame(len, 8, 1'b0);
		end else if (pick < 75) begin
			answer_frame(len, 8, 1'b1);
		end else if (pick < 85) begin
			// reply cut short, then ticks past the deadline when it is small
			repeat ($urandom_range(len + 6)) send_byte(8'($urandom));
			for (i = 0; i <= eng_timeout && i < 12; i++) send_action(ACT_TICK);
		end else begin
			send_command(8'($urandom), 5'($urandom));
			repeat ($urandom_range(1, 5)) send_item(make_item(action_t'($urandom_range(3))));
		end
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_METER_ADDRESS) eng_address = val;
		else eng_timeout = val[15:0];
	endtask

	// stop offering and wait out every pending result plus the engine's tail
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct,
			input logic [19:0] address, input logic [19:0] timeout, input int n);
		int stop_at;
		settle();
		write_register(REG_METER_ADDRESS, address);
		write_register(REG_TIMEOUT_TICKS, timeout);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		stop_at = items_sent + n;
		while (items_sent < stop_at) random_poll();
	endtask

	task automatic test_directed_cases();
		write_register(REG_METER_ADDRESS, 20'd999999);
		write_register(REG_TIMEOUT_TICKS, 20'd3);
		// byte and tick while idle do nothing
		send_byte(8'hFF);
		send_action(ACT_TICK);
		// shortest exchange, no payload
		send_action(ACT_BEGIN);
		send_command(8'hFF, 5'd0);
		answer_frame(0, 0, 1'b0);
		// oversized length, refused while waiting, begin while busy, then timeout
		send_command(8'h00, 5'd31);
		send_command(8'hA5, 5'd1);
		send_action(ACT_BEGIN);
		repeat (4) send_action(ACT_TICK);
		// latch holds until the next begin, then a corrupted reply
		send_command(8'h5A, 5'd0);
		send_action(ACT_BEGIN);
		send_command(8'h01, 5'd0);
		answer_frame(0, 0, 1'b1);
	endtask

	task automatic test_no_idle();
		run_random_phase(0, 0, 20'hFFFFF, 20'd0, 45);
	endtask

	task automatic test_sender_idle();
		run_random_phase(55, 0, 20'd0, 20'd65535, 45);
	endtask

	task automatic test_receiver_stall();
		run_random_phase(0, 55, 20'd999999, {4'hF, 16'd4}, 45);
	endtask

	task automatic test_both_idle();
		run_random_phase(31, 31, 20'($urandom_range(999999)), 20'($urandom_range(1, 12)), 45);
	endtask

	task automatic test_output_backpressure();
		settle();
		write_register(REG_TIMEOUT_TICKS, 20'd1000);
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_request       = 300;
		send_action(ACT_BEGIN);
		send_command(8'($urandom), 5'd16);
		answer_frame(PAYLOAD_MAX, 0, 1'b0);
		settle();
		send_action(ACT_BEGIN);
		send_command(8'($urandom), 5'd3);
		answer_frame(3, 0, 1'b0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_output_backpressure();
		settle();
		if (awaited.size() != 0) report_mismatch("results never delivered", 0, awaited.size());
		$display("covered %0d transactions in, %0d results checked, %0d mismatches",
			items_sent, results_seen, mismatches);
		$display("status mix: ok %0d, timeout %0d, bad crc %0d, refused %0d",
			status_tally[ST_OK], status_tally[ST_TIMEOUT], status_tally[ST_BAD_CRC],
			status_tally[ST_REFUSED]);
		if (mismatches == 0) begin
			$display("meter_poll_transaction_engine regression: pass");
		end else begin
			$display("meter_poll_transaction_engine regression: fail");
		end
		$finish;
	end

endmodule
